/* rtl/rfqm_pkg.sv */
// Package for the rotating four-queue manager.
// Holds the field widths, operation codes and status codes shared by the RTL.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfqm_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QSEL_W      = 2;
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;
  localparam int TOTAL_W     = 7;
  localparam int OUT_TDATA_W = 40;
  localparam int STATUS_W    = 2;

  localparam logic [QSEL_W-1:0] LAST_POS  = 2'd3;
  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* rtl/rfqm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Used as the shared element store of the queue manager. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rfqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rotating_four_queue_manager.sv */
// Top level of the rotating four-queue manager.
// Depends on rfqm_pkg and on rfqm_ram for the element store.
//
// Four FIFO queues share one store and are visited in a rotating order. An
// insert (tuser 0) goes to the first queue in order below the programmed
// capacity, capped at QUEUE_DEPTH, or is dropped with status 2; a pop
// (tuser 1) takes the head of the first non-empty queue, with status 1 when
// all are empty. When a pop empties a queue that is not last in order, the
// order rotates by one. One request is accepted every cycle while the output
// is not stalled; its result passes a pending register, where a pop's store
// read data is registered, and then the output register. The capacity
// register must only be written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rotating_four_queue_manager #(
  parameter int QUEUE_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rfqm_pkg::CAP_W-1:0]        cfg_wdata,      // queue_capacity
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [rfqm_pkg::DATA_W-1:0]       s_axis_tdata,   // value
  input  wire logic [0:0]                        s_axis_tuser,   // mode
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [rfqm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // popped_value, total_count, all_full
  output logic [rfqm_pkg::STATUS_W-1:0]          m_axis_tuser    // status
);

  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CAPW = (CW > rfqm_pkg::CAP_W) ? CW : rfqm_pkg::CAP_W;
  localparam int SW   = ((AW > CW) ? AW : CW) + 1;
  localparam int TW   = CW + 2;
  localparam int RAM_DEPTH = rfqm_pkg::NUM_QUEUES << AW;
  localparam int RAM_AW    = AW + rfqm_pkg::QSEL_W;

  logic [rfqm_pkg::CAP_W-1:0]  capacity;
  logic [CW-1:0]               count [rfqm_pkg::NUM_QUEUES];
  logic [AW-1:0]               head  [rfqm_pkg::NUM_QUEUES];
  logic [rfqm_pkg::QSEL_W-1:0] offset;

  logic                        p_valid;
  logic                        p_pop;
  rfqm_pkg::status_t           p_status;

  logic                        out_valid;
  logic [rfqm_pkg::DATA_W-1:0] out_popped;
  rfqm_pkg::status_t           out_status;
  logic [rfqm_pkg::TOTAL_W-1:0] out_total;
  logic                        out_all_full;

  logic [CAPW-1:0]             eff_cap;
  logic [rfqm_pkg::NUM_QUEUES-1:0] full_vec;
  logic [rfqm_pkg::NUM_QUEUES-1:0] busy_vec;
  logic [rfqm_pkg::NUM_QUEUES-1:0] free_rot;
  logic [rfqm_pkg::NUM_QUEUES-1:0] busy_rot;
  logic                        ins_found;
  logic                        pop_found;
  logic [rfqm_pkg::QSEL_W-1:0] ins_pos;
  logic [rfqm_pkg::QSEL_W-1:0] pop_pos;
  logic [rfqm_pkg::QSEL_W-1:0] sel_pos;
  logic [rfqm_pkg::QSEL_W-1:0] sel_q;
  logic [CW-1:0]               cnt_sel;
  logic [AW-1:0]               head_sel;
  logic [AW-1:0]               head_inc;
  logic [SW-1:0]               slot_sum;
  logic [AW-1:0]               slot;
  logic [TW-1:0]               total_sum;

  logic                        p_adv;
  logic                        accept;
  logic                        is_pop;
  logic                        do_ins;
  logic                        do_pop;
  logic [VALUE_WIDTH-1:0]      ram_wdata;
  logic [VALUE_WIDTH-1:0]      ram_rdata;
  logic [RAM_AW-1:0]           ram_waddr;
  logic [RAM_AW-1:0]           ram_raddr;

  // Queue selection and the totals seen after the last completed request.
  always_comb begin
    if (CAPW'(capacity) > CAPW'(QUEUE_DEPTH)) begin
      eff_cap = CAPW'(QUEUE_DEPTH);
    end else begin
      eff_cap = CAPW'(capacity);
    end
    total_sum = '0;
    for (int q = 0; q < rfqm_pkg::NUM_QUEUES; q++) begin
      full_vec[q] = (CAPW'(count[q]) >= eff_cap);
      busy_vec[q] = (count[q] != '0);
      total_sum   = total_sum + TW'(count[q]);
    end
    free_rot = rfqm_pkg::NUM_QUEUES'({~full_vec, ~full_vec} >> offset);
    busy_rot = rfqm_pkg::NUM_QUEUES'({busy_vec, busy_vec} >> offset);
    ins_found = 1'b0;
    pop_found = 1'b0;
    ins_pos   = '0;
    pop_pos   = '0;
    for (int p = rfqm_pkg::NUM_QUEUES - 1; p >= 0; p--) begin
      if (free_rot[p]) begin
        ins_found = 1'b1;
        ins_pos   = rfqm_pkg::QSEL_W'(p);
      end
      if (busy_rot[p]) begin
        pop_found = 1'b1;
        pop_pos   = rfqm_pkg::QSEL_W'(p);
      end
    end
    is_pop   = (s_axis_tuser[0] == rfqm_pkg::MODE_POP);
    sel_pos  = is_pop ? pop_pos : ins_pos;
    sel_q    = sel_pos + offset;
    cnt_sel  = count[sel_q];
    head_sel = head[sel_q];
    head_inc = (head_sel == AW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + AW'(1);
    slot_sum = SW'(head_sel) + SW'(cnt_sel);
    if (slot_sum >= SW'(QUEUE_DEPTH)) begin
      slot = AW'(slot_sum - SW'(QUEUE_DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  assign p_adv         = p_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !p_valid || p_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign do_ins        = accept && !is_pop && ins_found;
  assign do_pop        = accept && is_pop && pop_found;

  assign ram_wdata = VALUE_WIDTH'(s_axis_tdata);
  assign ram_waddr = {sel_q, slot};
  assign ram_raddr = {sel_q, head_sel};

  rfqm_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (do_ins),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (do_pop),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rfqm_pkg::CAP_RESET;
      offset   <= '0;
      for (int q = 0; q < rfqm_pkg::NUM_QUEUES; q++) begin
        count[q] <= '0;
        head[q]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (do_ins) begin
        count[sel_q] <= cnt_sel + CW'(1);
      end
      if (do_pop) begin
        count[sel_q] <= cnt_sel - CW'(1);
        head[sel_q]  <= head_inc;
        if (cnt_sel == CW'(1) && pop_pos != rfqm_pkg::LAST_POS) begin
          offset <= offset + rfqm_pkg::QSEL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_pop <= do_pop;
      if (is_pop) begin
        p_status <= pop_found ? rfqm_pkg::ST_OK : rfqm_pkg::ST_EMPTY;
      end else begin
        p_status <= ins_found ? rfqm_pkg::ST_OK : rfqm_pkg::ST_DROPPED;
      end
    end
  end

  // While a request waits here the queue state already reflects it alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_popped   <= p_pop ? rfqm_pkg::DATA_W'(ram_rdata) : '0;
      out_status   <= p_status;
      out_total    <= rfqm_pkg::TOTAL_W'(total_sum);
      out_all_full <= &full_vec;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_all_full, out_total, out_popped};
  assign m_axis_tuser  = out_status;

endmodule

`default_nettype wire
